>>> sv/sorted_code_set_with_cycle_step_defines.svh
// Assertion macros shared by the sorted code set RTL.
`ifndef SORTED_CODE_SET_WITH_CYCLE_STEP_DEFINES_SVH
`define SORTED_CODE_SET_WITH_CYCLE_STEP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define SCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the next cycle.
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	`SCS_ASSERT(lbl, (ante) |=> (cons), msg)

// Implication checked in the same cycle.
`define SCS_ASSERT_NOW(lbl, ante, cons, msg) \
	`SCS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> sv/scs_pkg.sv
// Shared types for the sorted code set: status codes and control/status structs.
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

	// Result status; a step transaction reports ST_INSERTED (zero).
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	typedef enum logic {
		RES_ECHO = 1'b0,
		RES_MEM  = 1'b1
	} res_sel_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_STEP   = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic     load;
		logic     rd_mid;
		logic     cmp_upd;
		logic     shift_start;
		logic     shift_step;
		logic     write_code;
		logic     fetch_first;
		logic     fetch_nbr;
		logic     load_res;
		res_sel_t res_sel;
		status_t  res_status;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic kind;
		logic code_zero;
		logic few_entries;
		logic lo_lt_hi;
		logic cmp_eq;
		logic full;
		logic shift_none;
		logic shift_last;
	} stat_t;

endpackage
`default_nettype wire

>>> sv/scs_dp.sv
// Datapath: code store memory, search bounds, shift pointer and result registers.
`timescale 1ns / 1ps
`default_nettype none
module scs_dp #(
	parameter int SET_DEPTH = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scs_pkg::cmd_t       cmd,
	output scs_pkg::stat_t           stat,
	input  wire logic                kind,
	input  wire logic [15:0]         code_value,
	input  wire logic signed [1:0]   step_direction,
	output logic [1:0]               status,
	output logic [15:0]              found_code,
	output logic [7:0]               entry_count
);
	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);

	logic [15:0]   mem [SET_DEPTH];
	logic [15:0]   rdata_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, ptr_q;
	logic [15:0]   code_q;
	logic          kind_q;
	logic [1:0]    dir_q;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic [CW-1:0] nbr;
	logic [CW-1:0] rd_idx;
	logic          rd_en;
	logic          wr_en;
	logic [CW-1:0] wr_idx;
	logic [15:0]   wr_data;
	logic [CW+7:0] count_ext;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];

	// wrap-around neighbor of the matched index
	always_comb begin
		priority if (dir_q[1]) begin
			nbr = (mid_q == '0) ? count_q - 1'b1 : mid_q - 1'b1;
		end else if (dir_q[0]) begin
			nbr = (mid_q + 1'b1 >= count_q) ? '0 : mid_q + 1'b1;
		end else begin
			nbr = mid_q;
		end
	end

	always_comb begin
		rd_en = cmd.rd_mid | cmd.shift_start | cmd.shift_step | cmd.fetch_first
			| cmd.fetch_nbr;
		priority if (cmd.rd_mid) begin
			rd_idx = mid;
		end else if (cmd.shift_start) begin
			rd_idx = count_q - 1'b1;
		end else if (cmd.shift_step) begin
			rd_idx = ptr_q - CW'(2);
		end else if (cmd.fetch_nbr) begin
			rd_idx = nbr;
		end else begin
			rd_idx = '0;
		end
		wr_en   = cmd.shift_step | cmd.write_code;
		wr_idx  = cmd.shift_step ? ptr_q : lo_q;
		wr_data = cmd.shift_step ? rdata_q : code_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.write_code) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= code_value;
			kind_q <= kind;
			dir_q  <= step_direction;
			lo_q   <= '0;
			hi_q   <= count_q;
		end
		if (cmd.rd_mid) begin
			mid_q <= mid;
		end
		if (cmd.cmp_upd) begin
			if (code_q < rdata_q) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + 1'b1;
			end
		end
		if (cmd.shift_start) begin
			ptr_q <= count_q;
		end else if (cmd.shift_step) begin
			ptr_q <= ptr_q - 1'b1;
		end
		if (cmd.load_res) begin
			status     <= cmd.res_status;
			found_code <= (cmd.res_sel == scs_pkg::RES_MEM) ? rdata_q : code_q;
			entry_count <= count_ext[7:0];
		end
	end

	assign count_ext = {8'd0, count_q};

	always_comb begin
		stat.kind        = kind_q;
		stat.code_zero   = (code_q == 16'd0);
		stat.few_entries = (count_q < CW'(2));
		stat.lo_lt_hi    = (lo_q < hi_q);
		stat.cmp_eq      = (code_q == rdata_q);
		stat.full        = (count_q >= CW'(SET_DEPTH));
		stat.shift_none  = (count_q == lo_q);
		stat.shift_last  = (ptr_q == lo_q + 1'b1);
	end
endmodule
`default_nettype wire

>>> sv/scs_ctrl.sv
// Controller: sequences search, shift, write and result load for one transaction.
`timescale 1ns / 1ps
`default_nettype none
module scs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire scs_pkg::stat_t stat,
	output scs_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);
	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SRCH_RD = 6'b000010,
		S_SRCH_CM = 6'b000100,
		S_SHIFT   = 6'b001000,
		S_WRITE   = 6'b010000,
		S_FINISH  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	scs_pkg::status_t   res_st_q, res_st_d;
	scs_pkg::res_sel_t  res_sel_q, res_sel_d;
	logic               done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		state_d   = state_q;
		res_st_d  = res_st_q;
		res_sel_d = res_sel_q;
		cmd       = '0;
		cmd.res_sel    = res_sel_q;
		cmd.res_status = res_st_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				res_sel_d = scs_pkg::RES_ECHO;
				res_st_d  = scs_pkg::ST_INSERTED;
				priority if (stat.kind == scs_pkg::KIND_INSERT && stat.code_zero) begin
					res_st_d = scs_pkg::ST_REJECTED;
					state_d  = S_FINISH;
				end else if (stat.kind == scs_pkg::KIND_STEP && stat.few_entries) begin
					state_d = S_FINISH;
				end else if (stat.lo_lt_hi) begin
					cmd.rd_mid = 1'b1;
					state_d    = S_SRCH_CM;
				end else if (stat.kind == scs_pkg::KIND_STEP) begin
					// absent: answer with the smallest entry
					cmd.fetch_first = 1'b1;
					res_sel_d       = scs_pkg::RES_MEM;
					state_d         = S_FINISH;
				end else if (stat.full) begin
					res_st_d = scs_pkg::ST_REJECTED;
					state_d  = S_FINISH;
				end else if (stat.shift_none) begin
					state_d = S_WRITE;
				end else begin
					cmd.shift_start = 1'b1;
					state_d         = S_SHIFT;
				end
			end
			S_SRCH_CM: begin
				priority if (stat.cmp_eq && stat.kind == scs_pkg::KIND_INSERT) begin
					res_st_d = scs_pkg::ST_PRESENT;
					state_d  = S_FINISH;
				end else if (stat.cmp_eq) begin
					cmd.fetch_nbr = 1'b1;
					res_sel_d     = scs_pkg::RES_MEM;
					state_d       = S_FINISH;
				end else begin
					cmd.cmp_upd = 1'b1;
					state_d     = S_SRCH_RD;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_last) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write_code = 1'b1;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				cmd.load_res = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_st_q  <= scs_pkg::ST_INSERTED;
			res_sel_q <= scs_pkg::RES_ECHO;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_st_q  <= res_st_d;
			res_sel_q <= res_sel_d;
			done_q    <= (state_q == S_FINISH);
		end
	end
endmodule
`default_nettype wire

>>> sv/sorted_code_set_with_cycle_step.sv
// One transaction at a time; a new start is taken only while the block is idle.
// The shift moves one entry per cycle through the single-write code store memory.
// busy is high from acceptance until the result strobe; done pulses for one cycle.
// arst_n clears the entry count and the controller; the code store is not cleared.
// The receiver cannot stall: the result registers hold from the done cycle until the next transaction completes.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_code_set_with_cycle_step_defines.svh"
module sorted_code_set_with_cycle_step #(
	parameter int SET_DEPTH = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [15:0]       code_value,
	input  wire logic signed [1:0] step_direction,
	output logic                   done,
	output logic [1:0]             status,
	output logic [15:0]            found_code,
	output logic [7:0]             entry_count
);
	// Command and status links between the sequencer and the datapath.
	scs_pkg::cmd_t  cmd;
	scs_pkg::stat_t stat;

	// Sequencer: binary search (read, then compare, per probe), the shift-up
	// pass for an insert, and the final result load.
	scs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: the ascending code store, bounds lo/hi, shift pointer and the
	// result registers that hold still until the next transaction completes.
	scs_dp #(
		.SET_DEPTH (SET_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.code_value     (code_value),
		.step_direction (step_direction),
		.status         (status),
		.found_code     (found_code),
		.entry_count    (entry_count)
	);

	// An accepted transaction always keeps the block busy in the next cycle.
	`SCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not set after accept")
	// The result strobe comes after the sequencer leaves its last state.
	`SCS_ASSERT_NOW(a_done_idle, done, !busy, "done while busy")
	// The result strobe is always preceded by a busy cycle.
	`SCS_ASSERT_NOW(a_done_after_busy, done, $past(busy), "done without prior work")
endmodule
`default_nettype wire
